// ===== sv/srpq_pkg.sv =====
// Package for the sorted insert priority queue.
// Holds the payload widths, the operation and status codes and the cell control type.
// Depends on nothing; every other file uses it.
`default_nettype none

package srpq_pkg;

   localparam int DATA_W  = 32;
   localparam int INDEX_W = 4;
   localparam int COUNT_W = 5;

   // Operation carried by a request.
   typedef enum logic {
      OP_INSERT = 1'b0,
      OP_READ   = 1'b1
   } op_type;

   // Status returned with every response.
   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_RANGE = 2'd2
   } status_type;

   // Control broadcast from the top level to every cell of the chain.
   typedef struct packed {
      logic                     shift_en;
      logic signed [DATA_W-1:0] value;
   } cell_ctrl_type;

endpackage

`default_nettype wire

// ===== sv/srpq_req_if.sv =====
// Request channel of the sorted insert priority queue.
// Carries valid, ready and the request payload; depends on srpq_pkg.
`default_nettype none

interface srpq_req_if;
   logic                             valid;
   logic                             ready;
   srpq_pkg::op_type                 op;
   logic signed [srpq_pkg::DATA_W-1:0] value;
   logic [srpq_pkg::INDEX_W-1:0]     index;

   modport source (output valid, output op, output value, output index, input ready);
   modport sink   (input valid, input op, input value, input index, output ready);
endinterface

`default_nettype wire

// ===== sv/srpq_rsp_if.sv =====
// Response channel of the sorted insert priority queue.
// Carries valid, ready and the response payload; depends on srpq_pkg.
`default_nettype none

interface srpq_rsp_if;
   logic                               valid;
   logic                               ready;
   logic signed [srpq_pkg::DATA_W-1:0] data;
   logic [srpq_pkg::INDEX_W-1:0]       position;
   logic [srpq_pkg::COUNT_W-1:0]       count;
   srpq_pkg::status_type               status;

   modport source (output valid, output data, output position, output count, output status,
                   input ready);
   modport sink   (input valid, input data, input position, input count, input status,
                   output ready);
endinterface

`default_nettype wire

// ===== sv/srpq_cell.sv =====
// One storage cell of the sorted chain.
// Holds one entry, compares it with the incoming value and takes its left neighbor on a shift.
// Depends on srpq_pkg.
`default_nettype none

module srpq_cell (
   input  logic                               clock,
   input  srpq_pkg::cell_ctrl_type            ctrl,
   input  logic                               below_count,
   input  logic                               left_lt,
   input  logic signed [srpq_pkg::DATA_W-1:0] left_entry,
   output logic                               lt,
   output logic signed [srpq_pkg::DATA_W-1:0] entry
);
   import srpq_pkg::*;

   logic signed [DATA_W-1:0] entry_ff, entry_in;

   // A live entry smaller than the new value stays where it is.
   assign lt    = below_count && (entry_ff < ctrl.value);
   assign entry = entry_ff;

   // The cell at the insert point takes the new value; cells above it take their neighbor.
   always_comb begin
      entry_in = entry_ff;
      if (ctrl.shift_en && !lt) begin
         entry_in = left_lt ? ctrl.value : left_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

`default_nettype wire

// ===== sv/sorted_insert_priority_queue_unit.sv =====
// Sorted insert priority queue: a chain of CAPACITY cells kept in ascending signed order.
// Requests arrive on req_chan: op insert places value in order, op read returns the entry
// at index. Every request gives exactly one response on rsp_chan with data, position,
// count (entries held after the request) and status.
// An insert compares the value in every cell at once; each cell then keeps its entry, takes
// the new value or takes its left neighbor, so the whole chain shifts on the same clock edge.
// An insert into a full queue is dropped with status full; a read at or past the count
// returns zero data with status range.
// The response is registered and is valid in the cycle after the request is accepted, and one
// request is taken every cycle while the receiver keeps taking responses. The response
// sits in an output register; a new request is taken whenever that register is empty or
// is being emptied in the same cycle, so a stalled receiver holds the block after one
// response is waiting.
// Reset empties the queue (count zero) and drops any waiting response, with no clearing
// pass over the entries.
// Depends on srpq_pkg, srpq_req_if, srpq_rsp_if and srpq_cell.
`default_nettype none

module sorted_insert_priority_queue_unit #(
   parameter int CAPACITY = 16
) (
   input  logic        clock,
   input  logic        reset,
   srpq_req_if.sink    req_chan,
   srpq_rsp_if.source  rsp_chan
);
   import srpq_pkg::*;

   localparam int CNT_W = $clog2(CAPACITY + 1);

   logic [CNT_W-1:0]         count_ff, count_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic [INDEX_W-1:0]       rsp_position_ff, rsp_position_in;
   logic [COUNT_W-1:0]       rsp_count_ff, rsp_count_in;
   status_type               rsp_status_ff, rsp_status_in;

   logic                     accept;
   logic                     full;
   logic                     is_insert;
   cell_ctrl_type            ctrl;
   logic [CAPACITY-1:0]      below_count;
   logic [CAPACITY-1:0]      cell_lt;
   logic [CAPACITY-1:0]      left_lt;
   logic [CAPACITY-1:0]      boundary;
   logic signed [DATA_W-1:0] cell_entry [CAPACITY];
   logic signed [DATA_W-1:0] left_entry [CAPACITY];
   logic [INDEX_W-1:0]       ins_position;
   logic signed [DATA_W-1:0] rd_data;
   logic                     rd_hit;

   // Handshake and broadcast control.
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept         = req_chan.valid && req_chan.ready;
   assign full           = (count_ff == CNT_W'(CAPACITY));
   assign is_insert      = (req_chan.op == OP_INSERT);
   assign ctrl.shift_en  = accept && is_insert && !full;
   assign ctrl.value     = req_chan.value;

   // The chain of cells, each fed by its left neighbor; cell zero sees an open slot on its left.
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      assign below_count[i] = (count_ff > CNT_W'(i));
      if (i == 0) begin : g_first
         assign left_lt[i]    = 1'b1;
         assign left_entry[i] = '0;
      end else begin : g_rest
         assign left_lt[i]    = cell_lt[i-1];
         assign left_entry[i] = cell_entry[i-1];
      end
      assign boundary[i] = left_lt[i] && !cell_lt[i];

      srpq_cell u_cell (
         .clock       (clock),
         .ctrl        (ctrl),
         .below_count (below_count[i]),
         .left_lt     (left_lt[i]),
         .left_entry  (left_entry[i]),
         .lt          (cell_lt[i]),
         .entry       (cell_entry[i])
      );
   end

   // The insert point is the one cell whose left neighbor stays and which itself moves.
   always_comb begin
      ins_position = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         if (boundary[i]) begin
            ins_position = ins_position | INDEX_W'(i);
         end
      end
   end

   // Read selection over the cells that the index field can reach.
   always_comb begin
      rd_data = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         if (32'(req_chan.index) == i) begin
            rd_data = rd_data | cell_entry[i];
         end
      end
   end
   assign rd_hit = (32'(req_chan.index) < 32'(count_ff));

   // Count of stored entries.
   always_comb begin
      count_in = count_ff;
      if (ctrl.shift_en) begin
         count_in = count_ff + CNT_W'(1);
      end
   end

   // Response payload for the request being accepted.
   always_comb begin
      rsp_data_in     = rsp_data_ff;
      rsp_position_in = rsp_position_ff;
      rsp_count_in    = rsp_count_ff;
      rsp_status_in   = rsp_status_ff;
      if (accept) begin
         rsp_count_in = COUNT_W'(count_in);
         if (is_insert) begin
            rsp_data_in     = req_chan.value;
            rsp_position_in = full ? '0 : ins_position;
            rsp_status_in   = full ? STATUS_FULL : STATUS_OK;
         end else begin
            rsp_data_in     = rd_hit ? rd_data : '0;
            rsp_position_in = req_chan.index;
            rsp_status_in   = rd_hit ? STATUS_OK : STATUS_RANGE;
         end
      end
   end

   // The output register fills on an accepted request and empties when the receiver takes it.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff     <= rsp_data_in;
      rsp_position_ff <= rsp_position_in;
      rsp_count_ff    <= rsp_count_in;
      rsp_status_ff   <= rsp_status_in;
   end

   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.data     = rsp_data_ff;
   assign rsp_chan.position = rsp_position_ff;
   assign rsp_chan.count    = rsp_count_ff;
   assign rsp_chan.status   = rsp_status_ff;

   // The queue never holds more than its capacity.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("stored count exceeds capacity");

   // An insert that is not dropped raises the count by exactly one.
   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      (accept && is_insert && !full) |=> (count_ff == $past(count_ff) + CNT_W'(1)))
      else $error("insert did not raise the count");

   // A dropped insert is only reported while the queue is full.
   a_full_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff == STATUS_FULL) |-> full)
      else $error("full status reported with room left");

endmodule

`default_nettype wire

// ===== tb/sorted_insert_priority_queue_unit_tb.sv =====
// Self-checking testbench for the sorted insert priority queue unit.
// Drives inserts and reads through srpq_req_if and checks every response on srpq_rsp_if
// against an in-bench sorted-array predictor; depends on srpq_pkg and both interfaces.
module sorted_insert_priority_queue_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import srpq_pkg::*;

   localparam int CAPACITY    = 16;
   localparam int CYCLE_LIMIT = 200000;
   localparam int MAX_IDLE    = 18;

   typedef struct {
      op_type                   op;
      logic signed [DATA_W-1:0] value;
      logic [INDEX_W-1:0]       index;
      bit                       drain;
   } queue_req_type;

   typedef struct {
      logic signed [DATA_W-1:0] data;
      logic [INDEX_W-1:0]       position;
      logic [COUNT_W-1:0]       count;
      status_type               status;
   } queue_rsp_type;

   logic clock = 1'b0;
   logic reset;

   srpq_req_if req_chan ();
   srpq_rsp_if rsp_chan ();

   sorted_insert_priority_queue_unit #(
      .CAPACITY(CAPACITY)
   ) dut (
      .clock   (clock),
      .reset   (reset),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan)
   );

   always #4 clock = ~clock;

   // Predictor state: the entries in ascending order and how many are held.
   logic signed [DATA_W-1:0] sorted_entries[CAPACITY];
   int                       entry_count = 0;

   queue_req_type            pending_requests[$];
   queue_rsp_type            expected_responses[$];
   logic signed [DATA_W-1:0] inserted_values[$];
   int                       queued_inserts = 0;

   queue_req_type launch_item;
   logic       req_fire = 1'b0;
   logic       rsp_taken = 1'b0;
   int         send_gap = 0;
   int         stall_count = 0;
   bit         sender_burst = 1'b0;
   bit         receiver_burst = 1'b0;
   int         cycle_count = 0;
   int         error_count = 0;

   // Apply one request to the predicted queue and return the response it should give.
   function automatic queue_rsp_type apply_request(input queue_req_type r);
      queue_rsp_type rsp;
      int         slot;
      int         k;
      if (r.op == OP_INSERT) begin
         if (entry_count >= CAPACITY) begin
            rsp.data     = r.value;
            rsp.position = '0;
            rsp.status   = STATUS_FULL;
         end else begin
            slot = 0;
            while (slot < entry_count && sorted_entries[slot] < r.value)
               slot++;
            for (k = entry_count; k > slot; k--)
               sorted_entries[k] = sorted_entries[k-1];
            sorted_entries[slot] = r.value;
            entry_count++;
            rsp.data     = r.value;
            rsp.position = slot[INDEX_W-1:0];
            rsp.status   = STATUS_OK;
         end
      end else if (int'(r.index) >= entry_count) begin
         rsp.data     = '0;
         rsp.position = r.index;
         rsp.status   = STATUS_RANGE;
      end else begin
         rsp.data     = sorted_entries[r.index];
         rsp.position = r.index;
         rsp.status   = STATUS_OK;
      end
      rsp.count = entry_count[COUNT_W-1:0];
      return rsp;
   endfunction

   task automatic add_insert(input logic signed [DATA_W-1:0] v, input bit drain);
      queue_req_type r;
      r.op    = OP_INSERT;
      r.value = v;
      r.index = INDEX_W'($urandom);
      r.drain = drain;
      pending_requests.push_back(r);
      inserted_values.push_back(v);
      queued_inserts++;
   endtask

   task automatic add_read(input logic [INDEX_W-1:0] idx, input bit drain);
      queue_req_type r;
      r.op    = OP_READ;
      r.value = DATA_W'($urandom);
      r.index = idx;
      r.drain = drain;
      pending_requests.push_back(r);
   endtask

   // Random insert value: full range, small signed, a repeat of an earlier value, or an extreme.
   function automatic logic signed [DATA_W-1:0] pick_value();
      int small_v;
      case ($urandom_range(0, 3))
         0: return DATA_W'($urandom);
         1: begin
            small_v = $urandom_range(0, 16);
            return DATA_W'(small_v - 8);
         end
         2: return inserted_values[$urandom_range(0, inserted_values.size() - 1)];
         default: begin
            case ($urandom_range(0, 3))
               0: return 32'sh8000_0000;
               1: return 32'sh8000_0001;
               2: return 32'sh7fff_fffe;
               default: return 32'sh7fff_ffff;
            endcase
         end
      endcase
   endfunction

   // Scoreboard: predict on every accepted request, check every accepted response.
   always @(posedge clock) begin
      queue_rsp_type want;
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end else begin
         req_fire  <= !reset && req_chan.valid && req_chan.ready;
         rsp_taken <= !reset && rsp_chan.valid && rsp_chan.ready;
         if (!reset && req_chan.valid && req_chan.ready) begin
            launch_item.op    = req_chan.op;
            launch_item.value = req_chan.value;
            launch_item.index = req_chan.index;
            expected_responses.push_back(apply_request(launch_item));
         end
         if (!reset && rsp_chan.valid && rsp_chan.ready) begin
            if (expected_responses.size() == 0) begin
               $error("response with no request outstanding: data %0d", rsp_chan.data);
               error_count++;
            end else begin
               want = expected_responses.pop_front();
               if (rsp_chan.data !== want.data) begin
                  $error("data: expected %0d, got %0d", want.data, rsp_chan.data);
                  error_count++;
               end
               if (rsp_chan.position !== want.position) begin
                  $error("position: expected %0d, got %0d", want.position, rsp_chan.position);
                  error_count++;
               end
               if (rsp_chan.count !== want.count) begin
                  $error("count: expected %0d, got %0d", want.count, rsp_chan.count);
                  error_count++;
               end
               if (rsp_chan.status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_chan.status);
                  error_count++;
               end
            end
         end
      end
   end

   // Request driver: holds a request until it is taken, then idles a drawn number of cycles.
   // A request marked drain waits until every outstanding response has come back.
   always @(negedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else if (!(req_chan.valid && !req_fire)) begin
         if (send_gap > 0) begin
            send_gap--;
            req_chan.valid <= 1'b0;
         end else if (pending_requests.size() != 0 &&
                      (!pending_requests[0].drain || expected_responses.size() == 0)) begin
            launch_item = pending_requests.pop_front();
            req_chan.valid <= 1'b1;
            req_chan.op    <= launch_item.op;
            req_chan.value <= launch_item.value;
            req_chan.index <= launch_item.index;
            if ($urandom_range(0, 40) == 0)
               sender_burst = !sender_burst;
            send_gap = sender_burst ? 0 : $urandom_range(0, MAX_IDLE);
         end else begin
            req_chan.valid <= 1'b0;
         end
      end
   end

   // Response receiver: after each response taken, ready drops for a drawn number of cycles.
   always @(negedge clock) begin
      if (rsp_taken) begin
         if ($urandom_range(0, 40) == 0)
            receiver_burst = !receiver_burst;
         stall_count = receiver_burst ? 0 : $urandom_range(0, MAX_IDLE);
      end
      if (stall_count > 0) begin
         stall_count--;
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= 1'b1;
      end
   end

   // Stimulus, reset and end of run.
   initial begin
      reset          = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.op    = OP_INSERT;
      req_chan.value = '0;
      req_chan.index = '0;
      rsp_chan.ready = 1'b0;

      // Directed: reads of an empty queue, extreme values, equal values, reads past the count.
      add_read(4'd0, 1'b0);
      add_read(4'd15, 1'b0);
      add_insert(32'sd0, 1'b0);
      add_insert(32'sh7fff_ffff, 1'b0);
      add_insert(32'sh8000_0000, 1'b0);
      add_insert(-32'sd1, 1'b0);
      add_insert(32'sd0, 1'b0);
      add_insert(32'sh8000_0000, 1'b0);
      for (int i = 0; i < 6; i++)
         add_read(INDEX_W'(i), 1'b0);
      add_read(4'd6, 1'b0);
      add_read(4'd15, 1'b0);

      // Random: fill the queue with interleaved reads, then reads and dropped inserts.
      for (int i = 0; i < 700; i++) begin
         if (queued_inserts < CAPACITY ? ($urandom_range(0, 1) == 0)
                                       : ($urandom_range(0, 4) == 0))
            add_insert(pick_value(), i == 0 || i == 350);
         else
            add_read(INDEX_W'($urandom_range(0, 15)), i == 0 || i == 350);
      end
      // One more insert after the queue is known full, checked in isolation.
      add_insert(32'sh7fff_ffff, 1'b1);
      add_read(4'd15, 1'b0);

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (pending_requests.size() != 0 || req_chan.valid)
         @(posedge clock);
      while (expected_responses.size() != 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
      if (error_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
